// ===== sv/y2r_pkg.sv =====
`default_nettype none

package y2r_pkg;

    localparam logic SRC_YUY2 = 1'b0;
    localparam logic SRC_Y210 = 1'b1;

    localparam logic [1:0] DST_BGRA8 = 2'd0;
    localparam logic [1:0] DST_RGB48 = 2'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FMT = 2'd1;

    localparam logic [15:0] ALPHA_NARROW = 16'd255;
    localparam logic [15:0] ALPHA_NONE   = 16'd0;
    localparam logic [15:0] ALPHA_WIDE   = 16'hffff;

    localparam int MQ_DEPTH = 8;
    localparam int OQ_DEPTH = 8;

    typedef struct packed {
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
        logic        has_second;
    } t_in_item;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        last_of_item;
    } t_out_pixel;

    typedef struct packed {
        logic       src;
        logic [1:0] dst;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/y2r_fifo.sv =====
`default_nettype none

module y2r_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/y2r_front.sv =====
`default_nettype none

module y2r_front #(
    parameter  int FRAC_BITS = 16,
    localparam int SW        = FRAC_BITS + 9,
    localparam int PW        = 2 * FRAC_BITS + 14
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire y2r_pkg::t_cfg            i_cfg,
    input  wire logic                     i_push,
    input  wire y2r_pkg::t_in_item        i_item,
    output logic                          o_full,
    input  wire logic                     i_mq_pop,
    output logic                          o_mq_push,
    output logic signed [SW-1:0]          o_c0,
    output logic signed [SW-1:0]          o_c1,
    output logic signed [PW-1:0]          o_tr,
    output logic signed [PW-1:0]          o_tg,
    output logic signed [PW-1:0]          o_tb,
    output logic                          o_has_second
);

    localparam int FM  = FRAC_BITS % 10;
    localparam int CW  = FRAC_BITS + 3;
    localparam int PW0 = SW + CW;
    localparam int QW  = FRAC_BITS - 9;
    localparam int RW  = $clog2(y2r_pkg::MQ_DEPTH) + 1;

    localparam logic [63:0] QF_W = ((64'd1 << FRAC_BITS) - (64'd1 << FM)) / 64'd1023;
    localparam logic [63:0] KR_W = ((64'd1792741 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] KG1_W = ((64'd213249 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] KG2_W = ((64'd532909 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] KB_W = ((64'd2112402 << FRAC_BITS) + 64'd500000) / 64'd1000000;

    localparam logic [QW-1:0]        QF  = QW'(QF_W);
    localparam logic signed [CW-1:0] KR  = CW'(KR_W);
    localparam logic signed [CW-1:0] KG1 = CW'(KG1_W);
    localparam logic signed [CW-1:0] KG2 = CW'(KG2_W);
    localparam logic signed [CW-1:0] KB  = CW'(KB_W);

    localparam logic [SW-1:0] OFF_Y = SW'(16) << FRAC_BITS;
    localparam logic [SW-1:0] OFF_C = SW'(128) << FRAC_BITS;

    typedef struct packed {
        logic [10:0] q;
        logic [9:0]  r;
    } t_div;

    typedef struct packed {
        logic [7:0] q;
        logic [9:0] r;
    } t_samp;

    function automatic t_div div1023(input logic [19:0] n);
        logic [9:0]  h;
        logic [10:0] m;
        t_div        res;
        h = n[19:10];
        m = {1'b0, n[9:0]} + {1'b0, h};
        if (m >= 11'd1023) begin
            res.q = {1'b0, h} + 11'd1;
            res.r = 10'(m - 11'd1023);
        end else begin
            res.q = {1'b0, h};
            res.r = m[9:0];
        end
        return res;
    endfunction

    function automatic t_samp prep(input logic [15:0] word, input logic src);
        logic [9:0]  s10;
        logic [17:0] p;
        t_div        d;
        t_samp       res;
        s10 = word[15:6];
        p   = {s10, 8'b0} - {8'b0, s10};
        d   = div1023({2'b0, p});
        if (src == y2r_pkg::SRC_Y210) begin
            res.q = d.q[7:0];
            res.r = d.r;
        end else begin
            res.q = word[7:0];
            res.r = '0;
        end
        return res;
    endfunction

    function automatic logic signed [SW-1:0] scale(input t_samp s, input logic [SW-1:0] offs);
        logic [19:0]   t;
        t_div          f;
        logic [SW-1:0] v;
        t = (20'(s.r) << FM) + 20'd511;
        f = div1023(t);
        v = (SW'(s.q) << FRAC_BITS) + (SW'(s.r) * SW'(QF)) + SW'(f.q);
        return signed'(v - offs);
    endfunction

    logic                  w_acc;
    logic [15:0]           w_cb_word;
    logic [15:0]           w_cr_word;
    logic [RW-1:0]         r_res;
    logic [RW-1:0]         n_res;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    t_samp                 r_s1_y0;
    t_samp                 r_s1_y1;
    t_samp                 r_s1_cb;
    t_samp                 r_s1_cr;
    logic                  r_s1_two;
    logic signed [SW-1:0]  r_s2_c0;
    logic signed [SW-1:0]  r_s2_c1;
    logic signed [SW-1:0]  r_s2_d;
    logic signed [SW-1:0]  r_s2_e;
    logic                  r_s2_two;
    logic signed [SW-1:0]  r_s3_c0;
    logic signed [SW-1:0]  r_s3_c1;
    logic signed [PW0-1:0] r_s3_pr;
    logic signed [PW0-1:0] r_s3_pg1;
    logic signed [PW0-1:0] r_s3_pg2;
    logic signed [PW0-1:0] r_s3_pb;
    logic                  r_s3_two;

    assign o_full = (r_res == RW'(y2r_pkg::MQ_DEPTH));
    assign w_acc  = i_push && !o_full;

    assign w_cb_word = (i_item.has_second && i_cfg.src == y2r_pkg::SRC_Y210) ?
                       i_item.word3 : i_item.word1;
    assign w_cr_word = (i_item.has_second && i_cfg.src == y2r_pkg::SRC_YUY2) ?
                       i_item.word3 : i_item.word1;

    always_comb begin
        n_res = r_res;
        if (w_acc && !i_mq_pop) begin
            n_res = r_res + 1'b1;
        end else if (!w_acc && i_mq_pop) begin
            n_res = r_res - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_res <= n_res;
            r_v1  <= w_acc;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_y0  <= prep(i_item.word0, i_cfg.src);
        r_s1_y1  <= prep(i_item.word2, i_cfg.src);
        r_s1_cb  <= prep(w_cb_word, i_cfg.src);
        r_s1_cr  <= prep(w_cr_word, i_cfg.src);
        r_s1_two <= i_item.has_second;

        r_s2_c0  <= scale(r_s1_y0, OFF_Y);
        r_s2_c1  <= scale(r_s1_y1, OFF_Y);
        r_s2_d   <= scale(r_s1_cb, OFF_C);
        r_s2_e   <= scale(r_s1_cr, OFF_C);
        r_s2_two <= r_s1_two;

        r_s3_c0  <= r_s2_c0;
        r_s3_c1  <= r_s2_c1;
        r_s3_pr  <= KR * r_s2_e;
        r_s3_pg1 <= KG1 * r_s2_d;
        r_s3_pg2 <= KG2 * r_s2_e;
        r_s3_pb  <= KB * r_s2_d;
        r_s3_two <= r_s2_two;
    end

    assign o_mq_push    = r_v3;
    assign o_c0         = r_s3_c0;
    assign o_c1         = r_s3_c1;
    assign o_tr         = PW'(r_s3_pr);
    assign o_tg         = -PW'(r_s3_pg1) - PW'(r_s3_pg2);
    assign o_tb         = PW'(r_s3_pb);
    assign o_has_second = r_s3_two;

endmodule

`default_nettype wire

// ===== sv/y2r_back.sv =====
`default_nettype none

module y2r_back #(
    parameter  int FRAC_BITS = 16,
    localparam int SW        = FRAC_BITS + 9,
    localparam int PW        = 2 * FRAC_BITS + 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire y2r_pkg::t_cfg        i_cfg,
    input  wire logic                 i_mq_empty,
    input  wire logic signed [SW-1:0] i_c0,
    input  wire logic signed [SW-1:0] i_c1,
    input  wire logic signed [PW-1:0] i_tr,
    input  wire logic signed [PW-1:0] i_tg,
    input  wire logic signed [PW-1:0] i_tb,
    input  wire logic                 i_has_second,
    output logic                      o_mq_pop,
    input  wire logic                 i_oq_pop,
    output logic                      o_oq_push,
    output y2r_pkg::t_out_pixel       o_pix
);

    localparam int CW  = FRAC_BITS + 3;
    localparam int PW0 = SW + CW;
    localparam int CHW = PW - FRAC_BITS;
    localparam int XW  = CHW + 10;
    localparam int OW  = $clog2(y2r_pkg::OQ_DEPTH) + 1;

    localparam logic [63:0] KY_W = ((64'd1164383 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic signed [CW-1:0] KY = CW'(KY_W);

    localparam logic signed [XW-1:0] HALF  = XW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [XW-1:0] TOP_N = XW'(255);
    localparam logic signed [XW-1:0] TOP_W = XW'(65535);

    function automatic logic [15:0] to_out(input logic signed [CHW-1:0] ch, input logic wide);
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] v;
        logic signed [XW-1:0] top;
        logic [15:0]          res;
        if (wide) begin
            x   = (XW'(ch) <<< 8) + XW'(ch) + HALF;
            top = TOP_W;
        end else begin
            x   = XW'(ch) + HALF;
            top = TOP_N;
        end
        v = x >>> FRAC_BITS;
        if (v < 0) begin
            res = 16'd0;
        end else if (v > top) begin
            res = top[15:0];
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    logic                  w_issue;
    logic                  w_last;
    logic                  w_wide;
    logic [15:0]           w_alpha;
    logic signed [PW-1:0]  w_sr;
    logic signed [PW-1:0]  w_sg;
    logic signed [PW-1:0]  w_sb;
    logic [OW-1:0]         r_ores;
    logic [OW-1:0]         n_ores;
    logic                  r_sel;
    logic                  r_b1_v;
    logic                  r_b2_v;
    logic                  r_b3_v;
    logic                  r_b4_v;
    logic signed [SW-1:0]  r_b1_c;
    logic signed [PW-1:0]  r_b1_tr;
    logic signed [PW-1:0]  r_b1_tg;
    logic signed [PW-1:0]  r_b1_tb;
    logic                  r_b1_last;
    logic signed [PW0-1:0] r_b2_pc;
    logic signed [PW-1:0]  r_b2_tr;
    logic signed [PW-1:0]  r_b2_tg;
    logic signed [PW-1:0]  r_b2_tb;
    logic                  r_b2_last;
    logic signed [CHW-1:0] r_b3_r;
    logic signed [CHW-1:0] r_b3_g;
    logic signed [CHW-1:0] r_b3_b;
    logic                  r_b3_last;
    y2r_pkg::t_out_pixel   r_b4_pix;

    assign w_issue  = !i_mq_empty && (r_ores != OW'(y2r_pkg::OQ_DEPTH));
    assign w_last   = !i_has_second || r_sel;
    assign o_mq_pop = w_issue && w_last;

    assign w_wide = (i_cfg.dst != y2r_pkg::DST_BGRA8);

    always_comb begin
        unique case (i_cfg.dst)
            y2r_pkg::DST_BGRA8: w_alpha = y2r_pkg::ALPHA_NARROW;
            y2r_pkg::DST_RGB48: w_alpha = y2r_pkg::ALPHA_NONE;
            default:            w_alpha = y2r_pkg::ALPHA_WIDE;
        endcase
    end

    always_comb begin
        n_ores = r_ores;
        if (w_issue && !i_oq_pop) begin
            n_ores = r_ores + 1'b1;
        end else if (!w_issue && i_oq_pop) begin
            n_ores = r_ores - 1'b1;
        end
    end

    assign w_sr = PW'(r_b2_pc) + r_b2_tr;
    assign w_sg = PW'(r_b2_pc) + r_b2_tg;
    assign w_sb = PW'(r_b2_pc) + r_b2_tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ores <= '0;
            r_sel  <= 1'b0;
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
        end else begin
            r_ores <= n_ores;
            if (w_issue) begin
                r_sel <= !w_last;
            end
            r_b1_v <= w_issue;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_c    <= r_sel ? i_c1 : i_c0;
        r_b1_tr   <= i_tr;
        r_b1_tg   <= i_tg;
        r_b1_tb   <= i_tb;
        r_b1_last <= w_last;

        r_b2_pc   <= KY * r_b1_c;
        r_b2_tr   <= r_b1_tr;
        r_b2_tg   <= r_b1_tg;
        r_b2_tb   <= r_b1_tb;
        r_b2_last <= r_b1_last;

        r_b3_r    <= CHW'(w_sr >>> FRAC_BITS);
        r_b3_g    <= CHW'(w_sg >>> FRAC_BITS);
        r_b3_b    <= CHW'(w_sb >>> FRAC_BITS);
        r_b3_last <= r_b2_last;

        r_b4_pix.red          <= to_out(r_b3_r, w_wide);
        r_b4_pix.green        <= to_out(r_b3_g, w_wide);
        r_b4_pix.blue         <= to_out(r_b3_b, w_wide);
        r_b4_pix.alpha        <= w_alpha;
        r_b4_pix.last_of_item <= r_b3_last;
    end

    assign o_oq_push = r_b4_v;
    assign o_pix     = r_b4_pix;

endmodule

`default_nettype wire

// ===== sv/yuv422_to_rgb_converter.sv =====
`default_nettype none

// YCbCr 4:2:2 (YUY2 or Y210) to RGB converter, BT.709 limited range, fixed point with
// FRAC_BITS fractional bits. One request is a macropixel; it yields two pixels, or one
// when has_second is low. The front end accepts a request every cycle while its 8-entry
// queue has room; the back end emits one pixel per cycle, while the middle queue holds
// an entry and the output queue has room, through its single luma multiplier, so a
// two-pixel macropixel is issued as two pixels in turn. Configuration writes are always
// ready and must only be issued while the block is idle.
module yuv422_to_rgb_converter #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    input  wire y2r_pkg::t_in_item                  i_item,
    output logic                                    full,
    output logic                                    empty,
    input  wire logic                               pop,
    output y2r_pkg::t_out_pixel                     o_pixel,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [y2r_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [y2r_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SW = FRAC_BITS + 9;
    localparam int PW = 2 * FRAC_BITS + 14;

    typedef struct packed {
        logic signed [SW-1:0] c0;
        logic signed [SW-1:0] c1;
        logic signed [PW-1:0] tr;
        logic signed [PW-1:0] tg;
        logic signed [PW-1:0] tb;
        logic                 has_second;
    } t_mq_entry;

    y2r_pkg::t_cfg       r_cfg;
    y2r_pkg::t_cfg       n_cfg;
    t_mq_entry           w_mq_wdata;
    t_mq_entry           w_mq_rdata;
    logic                w_mq_push;
    logic                w_mq_pop;
    logic                w_mq_empty;
    logic                w_oq_push;
    logic                w_oq_pop;
    y2r_pkg::t_out_pixel w_oq_wdata;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                y2r_pkg::REG_SRC_FMT: n_cfg.src = i_cfg_data[0];
                y2r_pkg::REG_DST_FMT: n_cfg.dst = i_cfg_data[1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src <= y2r_pkg::SRC_YUY2;
            r_cfg.dst <= y2r_pkg::DST_BGRA8;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    y2r_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_item       (i_item),
        .o_full       (full),
        .i_mq_pop     (w_mq_pop),
        .o_mq_push    (w_mq_push),
        .o_c0         (w_mq_wdata.c0),
        .o_c1         (w_mq_wdata.c1),
        .o_tr         (w_mq_wdata.tr),
        .o_tg         (w_mq_wdata.tg),
        .o_tb         (w_mq_wdata.tb),
        .o_has_second (w_mq_wdata.has_second)
    );

    y2r_fifo #(
        .W     ($bits(t_mq_entry)),
        .DEPTH (y2r_pkg::MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mq_push),
        .i_data  (w_mq_wdata),
        .i_pop   (w_mq_pop),
        .o_data  (w_mq_rdata),
        .o_empty (w_mq_empty)
    );

    y2r_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_mq_empty   (w_mq_empty),
        .i_c0         (w_mq_rdata.c0),
        .i_c1         (w_mq_rdata.c1),
        .i_tr         (w_mq_rdata.tr),
        .i_tg         (w_mq_rdata.tg),
        .i_tb         (w_mq_rdata.tb),
        .i_has_second (w_mq_rdata.has_second),
        .o_mq_pop     (w_mq_pop),
        .i_oq_pop     (w_oq_pop),
        .o_oq_push    (w_oq_push),
        .o_pix        (w_oq_wdata)
    );

    assign w_oq_pop = pop && !empty;

    y2r_fifo #(
        .W     ($bits(y2r_pkg::t_out_pixel)),
        .DEPTH (y2r_pkg::OQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_data  (w_oq_wdata),
        .i_pop   (w_oq_pop),
        .o_data  (o_pixel),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// ===== sv/y2r_port_check.sv =====
`default_nettype none

module y2r_port_check (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire y2r_pkg::t_out_pixel i_pixel
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(i_pixel))
        else $error("waiting result changed");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (i_pixel.alpha == 16'd255 || i_pixel.alpha == 16'd0 ||
                    i_pixel.alpha == 16'hffff))
        else $error("alpha outside format set");

    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && i_pixel.alpha == 16'd255 |->
            i_pixel.red <= 16'd255 && i_pixel.green <= 16'd255 && i_pixel.blue <= 16'd255)
        else $error("8-bit pixel out of range");

endmodule

bind yuv422_to_rgb_converter y2r_port_check u_y2r_port_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .i_pixel (o_pixel)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import y2r_pkg::*;

    localparam int FRAC_BITS = 16;

    localparam logic [1:0] DST_RGBA64   = 2'd2;
    localparam logic [1:0] DST_RESERVED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int RAND_PHASES      = 10;
    localparam int ITEMS_PER_PHASE  = 60;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct {
        logic       src;
        logic [1:0] dst;
        t_in_item   item;
        bit         typed;
        logic [15:0] chan;
        logic [15:0] alpha;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    t_in_item              i_item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    t_out_pixel            o_pixel;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic       cur_src;
    logic [1:0] cur_dst;

    t_out_pixel pending_pixels[$];
    t_dir_row   dir_rows[$];

    int mismatches;
    int pixels_checked;
    int macropixels_sent;
    int reg_writes;
    int burst_left;
    int gap_max;
    int rx_cycle;
    int pop_mode;

    yuv422_to_rgb_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .i_item(i_item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .o_pixel(o_pixel),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint coef(longint micro);
        return ((micro <<< FRAC_BITS) + 500000) / 1000000;
    endfunction

    function automatic longint scale_word(logic [15:0] word);
        longint s10;
        if (cur_src == SRC_Y210) begin
            s10 = longint'(word[15:6]);
            return ((s10 * 255) <<< FRAC_BITS) / 1023 + 0 * s10 +
                   ((((s10 * 255) <<< FRAC_BITS) % 1023) >= 512 ? 1 : 0);
        end
        return longint'(word[7:0]) <<< FRAC_BITS;
    endfunction

    function automatic logic [15:0] pack_channel(longint ch, bit wide);
        longint v;
        longint top;
        top = wide ? 65535 : 255;
        if (wide) ch = ch * 257;
        v = (ch + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v[15:0];
    endfunction

    function automatic t_out_pixel yuv_to_pixel(longint yv, longint cb, longint cr, bit last);
        t_out_pixel px;
        longint c;
        longint d;
        longint e;
        bit     wide;
        c = yv - (longint'(16) <<< FRAC_BITS);
        d = cb - (longint'(128) <<< FRAC_BITS);
        e = cr - (longint'(128) <<< FRAC_BITS);
        wide = (cur_dst != DST_BGRA8);
        px.red   = pack_channel((coef(1164383) * c + coef(1792741) * e) >>> FRAC_BITS, wide);
        px.green = pack_channel((coef(1164383) * c - coef(213249) * d
                                 - coef(532909) * e) >>> FRAC_BITS, wide);
        px.blue  = pack_channel((coef(1164383) * c + coef(2112402) * d) >>> FRAC_BITS, wide);
        case (cur_dst)
            DST_BGRA8: px.alpha = ALPHA_NARROW;
            DST_RGB48: px.alpha = ALPHA_NONE;
            default:   px.alpha = ALPHA_WIDE;
        endcase
        px.last_of_item = last;
        return px;
    endfunction

    task automatic convert_macropixel(t_in_item it);
        longint y0;
        longint c1;
        longint y1;
        longint c3;
        y0 = scale_word(it.word0);
        c1 = scale_word(it.word1);
        if (!it.has_second) begin
            pending_pixels.push_back(yuv_to_pixel(y0, c1, c1, 1'b1));
        end else begin
            y1 = scale_word(it.word2);
            c3 = scale_word(it.word3);
            if (cur_src == SRC_Y210) begin
                pending_pixels.push_back(yuv_to_pixel(y0, c3, c1, 1'b0));
                pending_pixels.push_back(yuv_to_pixel(y1, c3, c1, 1'b1));
            end else begin
                pending_pixels.push_back(yuv_to_pixel(y0, c1, c3, 1'b0));
                pending_pixels.push_back(yuv_to_pixel(y1, c1, c3, 1'b1));
            end
        end
    endtask

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_error($sformatf("pixel %0d %s got %0d want %0d",
                                   pixels_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_error("pixel popped with nothing pending");
            end else begin
                check_field("red", o_pixel.red, pending_pixels[0].red);
                check_field("green", o_pixel.green, pending_pixels[0].green);
                check_field("blue", o_pixel.blue, pending_pixels[0].blue);
                check_field("alpha", o_pixel.alpha, pending_pixels[0].alpha);
                check_field("last_of_item", 16'(o_pixel.last_of_item),
                            16'(pending_pixels[0].last_of_item));
                void'(pending_pixels.pop_front());
            end
            pixels_checked++;
        end
    end

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) pop_mode <= $urandom_range(0, 3);
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= (rx_cycle % 5 < 2);
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SRC_FMT) cur_src = data[0];
        else if (idx == REG_DST_FMT) cur_dst = data[1:0];
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_formats(logic src, logic [1:0] dst);
        write_reg(REG_SRC_FMT, {7'($urandom), src});
        write_reg(REG_DST_FMT, {6'($urandom), dst});
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
    endtask

    task automatic pace_sender();
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                push = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic push_macropixel(t_in_item it, bit typed, logic [15:0] chan,
                                   logic [15:0] alpha);
        t_out_pixel px;
        i_item = it;
        push   = 1'b1;
        do @(posedge i_clk); while (full);
        if (typed) begin
            px.red = chan;
            px.green = chan;
            px.blue = chan;
            px.alpha = alpha;
            px.last_of_item = !it.has_second;
            pending_pixels.push_back(px);
            if (it.has_second) begin
                px.last_of_item = 1'b1;
                pending_pixels.push_back(px);
            end
        end else begin
            convert_macropixel(it);
        end
        macropixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_row(logic src, logic [1:0] dst, logic [15:0] w0, logic [15:0] w1,
                           logic [15:0] w2, logic [15:0] w3, logic two, bit typed,
                           logic [15:0] chan, logic [15:0] alpha);
        t_dir_row row;
        row.src = src;
        row.dst = dst;
        row.item = '{word0: w0, word1: w1, word2: w2, word3: w3, has_second: two};
        row.typed = typed;
        row.chan = chan;
        row.alpha = alpha;
        dir_rows.push_back(row);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_in_item it;
        push        = 1'b0;
        pop         = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        cur_src     = SRC_YUY2;
        cur_dst     = DST_BGRA8;
        mismatches  = 0;
        pixels_checked   = 0;
        macropixels_sent = 0;
        reg_writes  = 0;
        burst_left  = 0;
        gap_max     = 3;
        rx_cycle    = 0;
        pop_mode    = 0;

        add_row(SRC_YUY2, DST_BGRA8, 16, 128, 16, 128, 1, 1, 0, ALPHA_NARROW);
        add_row(SRC_YUY2, DST_BGRA8, 235, 128, 235, 128, 1, 1, 255, ALPHA_NARROW);
        add_row(SRC_YUY2, DST_BGRA8, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(SRC_YUY2, DST_BGRA8, 255, 255, 255, 255, 1, 0, 0, 0);
        add_row(SRC_YUY2, DST_BGRA8, 16'hff10, 16'hab80, 16'h12eb, 16'hcd80, 1, 0, 0, 0);
        add_row(SRC_YUY2, DST_BGRA8, 120, 60, 16'hffff, 16'hffff, 0, 0, 0, 0);
        add_row(SRC_YUY2, DST_BGRA8, 81, 90, 145, 240, 1, 0, 0, 0);
        add_row(SRC_YUY2, DST_RGB48, 235, 128, 235, 128, 1, 1, 16'hffff, ALPHA_NONE);
        add_row(SRC_YUY2, DST_RGB48, 0, 128, 0, 128, 1, 1, 0, ALPHA_NONE);
        add_row(SRC_YUY2, DST_RGB48, 200, 40, 60, 220, 1, 0, 0, 0);
        add_row(SRC_YUY2, DST_RGBA64, 255, 128, 255, 128, 1, 1, 16'hffff, ALPHA_WIDE);
        add_row(SRC_YUY2, DST_RGBA64, 41, 240, 41, 110, 0, 0, 0, 0);
        add_row(SRC_YUY2, DST_RESERVED, 235, 128, 235, 128, 1, 1, 16'hffff, ALPHA_WIDE);
        add_row(SRC_YUY2, DST_RESERVED, 100, 20, 180, 200, 1, 0, 0, 0);
        add_row(SRC_Y210, DST_RGBA64, 16'hffc0, 16'h8000, 16'hffc0, 16'h8000, 1, 1,
                16'hffff, ALPHA_WIDE);
        add_row(SRC_Y210, DST_RGBA64, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 1, 1,
                0, ALPHA_WIDE);
        add_row(SRC_Y210, DST_BGRA8, 16'h403f, 16'h803f, 16'hb03f, 16'h203f, 1, 0, 0, 0);
        add_row(SRC_Y210, DST_BGRA8, 16'h7fc0, 16'hffc0, 16'h0000, 16'h0000, 0, 0, 0, 0);
        add_row(SRC_Y210, DST_RGB48, 16'hffff, 16'h0000, 16'hffff, 16'hffff, 1, 0, 0, 0);
        add_row(SRC_Y210, DST_RGB48, 16'h1000, 16'hf000, 16'heb00, 16'h1000, 1, 0, 0, 0);
        add_row(SRC_Y210, DST_RESERVED, 16'h2a40, 16'h3c80, 16'hd5c0, 16'hc400, 0, 0, 0, 0);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].src != cur_src || dir_rows[i].dst != cur_dst) begin
                wait_drained();
                set_formats(dir_rows[i].src, dir_rows[i].dst);
            end
            pace_sender();
            push_macropixel(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].chan,
                            dir_rows[i].alpha);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            if (p < 8) set_formats(p[0], 2'(p >> 1));
            else set_formats(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                it.word0 = rand_word();
                it.word1 = rand_word();
                it.word2 = rand_word();
                it.word3 = rand_word();
                it.has_second = ($urandom_range(0, 6) != 0);
                pace_sender();
                push_macropixel(it, 1'b0, '0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_pixels.size() != 0)
            report_error($sformatf("%0d pixels never arrived", pending_pixels.size()));

        $display("Sent %0d macropixels, checked %0d pixels, %0d register writes",
                 macropixels_sent, pixels_checked, reg_writes);
        $display("Both source packings, all four destination codes, lone pixels, stalls");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
